// ===== sv/csdp_pkg.sv =====
// ----------------------------------------------------------------------------
// csdp_pkg
// Shared types, constants and tables for the consensus score block.
// ----------------------------------------------------------------------------
package csdp_pkg;

    localparam int MAX_ROWS      = 32;
    localparam int FRACTION_BITS = 16;
    localparam int ROW_W         = 5;
    localparam int RES_W         = 3;
    localparam int GRP_W         = 5;
    localparam int CODE_W        = 4;
    localparam int SCORE_W       = 33;
    localparam int CNT_W         = 6;

    localparam logic [SCORE_W-1:0] SCORE_MAX   = {SCORE_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_TWO   = SCORE_W'(2) << FRACTION_BITS;
    localparam logic [SCORE_W-1:0] SCORE_ONE   = SCORE_W'(1) << FRACTION_BITS;
    localparam logic [63:0] THIRD_SCALED32     = 64'd1782572486;
    localparam logic [63:0] THIRD_RND          =
        (THIRD_SCALED32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
    localparam logic [SCORE_W-1:0] SCORE_THIRD = THIRD_RND[SCORE_W-1:0];

    localparam logic [CODE_W-1:0] CODE_N = 4'd14;
    localparam logic [RES_W-1:0]  RES_N  = 3'd4;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [RES_W-1:0] residue_code;
        logic [GRP_W-1:0] group_id;
        logic             last_in_column;
        logic             last_column;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic [CODE_W-1:0]  consensus_code;
        logic [ROW_W-1:0]   row_out;
        logic [SCORE_W-1:0] row_score;
        logic               keep;
        logic               last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic             load;       // store accepted item
        logic             clr_block;  // zero scores and block mask at block start
        logic             cons;       // form consensus
        logic             score;      // score row at idx
        logic             clr_col;    // drop column mask and base counts
        logic             cmp_load;   // latch row r for verdict
        logic             cmp_step;   // compare against row q
        logic [ROW_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic             col_hit;    // row idx in column mask
        logic             blk_hit;    // row idx in block mask
        logic             blk_more;   // a later row is in the block mask
        logic [CODE_W-1:0] cons_code;
        logic [SCORE_W-1:0] cur_score;
        logic             keep;
    } t_stat;

    function automatic logic [3:0] code_bases(input logic [CODE_W-1:0] c);
        case (c)
            4'd0: code_bases = 4'd1;   4'd1: code_bases = 4'd2;
            4'd2: code_bases = 4'd4;   4'd3: code_bases = 4'd8;
            4'd4: code_bases = 4'd3;   4'd5: code_bases = 4'd5;
            4'd6: code_bases = 4'd9;   4'd7: code_bases = 4'd6;
            4'd8: code_bases = 4'd10;  4'd9: code_bases = 4'd12;
            4'd10: code_bases = 4'd7;  4'd11: code_bases = 4'd11;
            4'd12: code_bases = 4'd13; 4'd13: code_bases = 4'd14;
            default: code_bases = 4'd15;
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] code_of_set(input logic [3:0] s);
        case (s)
            4'd1: code_of_set = 4'd0;  4'd2: code_of_set = 4'd1;
            4'd3: code_of_set = 4'd4;  4'd4: code_of_set = 4'd2;
            4'd5: code_of_set = 4'd5;  4'd6: code_of_set = 4'd7;
            4'd7: code_of_set = 4'd10; 4'd8: code_of_set = 4'd3;
            4'd9: code_of_set = 4'd6;  4'd10: code_of_set = 4'd8;
            4'd11: code_of_set = 4'd11; 4'd12: code_of_set = 4'd9;
            4'd13: code_of_set = 4'd12; 4'd14: code_of_set = 4'd13;
            default: code_of_set = CODE_N;
        endcase
    endfunction

    function automatic logic [SCORE_W-1:0] residue_score(input logic [CODE_W-1:0] cons,
                                                         input logic [RES_W-1:0] res);
        logic [3:0] b;
        logic [2:0] n;
        logic       hit;
        b   = code_bases(cons);
        n   = 3'(b[0]) + 3'(b[1]) + 3'(b[2]) + 3'(b[3]);
        hit = (res <= 3'd3) ? b[res[1:0]] : 1'b0;
        if (cons >= CODE_N || res == RES_N)
            residue_score = '0;
        else if (n == 3'd3)
            residue_score = (res > 3'd3 || hit) ? SCORE_THIRD : '0;
        else if (!hit)
            residue_score = '0;
        else
            residue_score = (n == 3'd1) ? SCORE_TWO : SCORE_ONE;
    endfunction

endpackage

// ===== sv/consensus_score_duplicate_pick_top.sv =====
// ----------------------------------------------------------------------------
// consensus_score_duplicate_pick_top
// IUPAC column consensus, per-row bit scoring and best-of-group verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one residue per transfer with its
//   row, species group and column/block end flags. Output channel
//   o_valid/i_ready carries results: a consensus code at every column end,
//   then at block end one verdict per row seen in the block, in row order.
//   The last result caused by an input has last set.
// Timing:
//   A residue that does not close a column leaves the sequencer idle and
//   ready for the next one. A column end forms the consensus, emits it,
//   then walks all MAX_ROWS row slots to update the score accumulators.
//   Results pass the sequencer's result register and the output register.
//   A block end then walks the row slots up to the last row present,
//   skipping absent slots and comparing each present row with every slot.
// Reset:
//   i_rst_n low at a clock edge clears the masks, counters and sequencer.
//   Row stores are undefined until written; scores clear at block start.
// Stall:
//   When i_ready is low the held result stays on the outputs and the
//   sequencer waits; no input transfer is taken until the item is done.
// ----------------------------------------------------------------------------
module consensus_score_duplicate_pick_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  csdp_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output csdp_pkg::t_out o_item
);
    import csdp_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ctl_valid, ctl_ready;
    t_out  ctl_item;

    csdp_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_item),
        .i_cmd  (cmd),
        .o_stat (stat)
    );

    csdp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_valid(ctl_valid),
        .i_ready(ctl_ready),
        .o_item (ctl_item)
    );

    // register each result before the output port
    csdp_last u_last (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(ctl_valid),
        .o_ready(ctl_ready),
        .i_item (ctl_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

endmodule

// ===== sv/csdp_datapath.sv =====
// ----------------------------------------------------------------------------
// csdp_datapath
// Row stores, base counters, score accumulators and the verdict comparator.
// ----------------------------------------------------------------------------
module csdp_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csdp_pkg::t_in   i_item,
    input  csdp_pkg::t_cmd  i_cmd,
    output csdp_pkg::t_stat o_stat
);
    import csdp_pkg::*;

    logic [RES_W-1:0]   r_res   [MAX_ROWS];
    logic [GRP_W-1:0]   r_grp   [MAX_ROWS];
    logic [SCORE_W-1:0] r_score [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_col_mask, r_blk_mask;
    logic [CNT_W-1:0]   r_cnt [5];
    logic [CODE_W-1:0]  r_cons;
    logic [GRP_W-1:0]   r_cmp_grp;
    logic [SCORE_W-1:0] r_cmp_score;
    logic [ROW_W-1:0]   r_cmp_row;
    logic               r_keep;

    logic [CNT_W-1:0]   top;
    logic [3:0]         set;
    logic [CODE_W-1:0]  cons_now;
    logic [SCORE_W:0]   sum;
    logic [MAX_ROWS-1:0] above;

    // consensus from counts
    always_comb begin
        top = r_cnt[0];
        for (int i = 1; i < 5; i++)
            if (r_cnt[i] > top) top = r_cnt[i];
        for (int i = 0; i < 4; i++)
            set[i] = (r_cnt[i] == top);
        cons_now = (r_cnt[4] == top) ? CODE_N : code_of_set(set);
    end

    assign sum = {1'b0, r_score[i_cmd.idx]} +
                 {1'b0, residue_score(r_cons, r_res[i_cmd.idx])};
    assign above = ({MAX_ROWS{1'b1}} << i_cmd.idx) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_mask <= '0;
            r_blk_mask <= '0;
            for (int i = 0; i < 5; i++) r_cnt[i] <= '0;
        end else begin
            if (i_cmd.clr_block)
                for (int i = 0; i < MAX_ROWS; i++) r_score[i] <= '0;
            if (i_cmd.load) begin
                // undo a replaced residue, then count the new one
                if (!(r_col_mask[i_item.row] && r_res[i_item.row] == i_item.residue_code))
                begin
                    if (r_col_mask[i_item.row] && r_res[i_item.row] < 3'd5)
                        r_cnt[r_res[i_item.row]] <= r_cnt[r_res[i_item.row]] - CNT_W'(1);
                    if (i_item.residue_code < 3'd5)
                        r_cnt[i_item.residue_code] <=
                            r_cnt[i_item.residue_code] + CNT_W'(1);
                end
                r_res[i_item.row] <= i_item.residue_code;
                r_grp[i_item.row] <= i_item.group_id;
                r_col_mask[i_item.row] <= 1'b1;
                r_blk_mask <= (i_cmd.clr_block ? '0 : r_blk_mask) |
                              (MAX_ROWS'(1) << i_item.row);
            end
            if (i_cmd.cons) r_cons <= cons_now;
            if (i_cmd.score && r_col_mask[i_cmd.idx])
                r_score[i_cmd.idx] <= sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
            if (i_cmd.clr_col) begin
                r_col_mask <= '0;
                for (int i = 0; i < 5; i++) r_cnt[i] <= '0;
            end
            if (i_cmd.cmp_load) begin
                r_cmp_row   <= i_cmd.idx;
                r_cmp_grp   <= r_grp[i_cmd.idx];
                r_cmp_score <= r_score[i_cmd.idx];
                r_keep      <= 1'b1;
            end
            if (i_cmd.cmp_step && r_blk_mask[i_cmd.idx] && i_cmd.idx != r_cmp_row
                && r_grp[i_cmd.idx] == r_cmp_grp
                && (r_score[i_cmd.idx] > r_cmp_score
                    || (r_score[i_cmd.idx] == r_cmp_score && i_cmd.idx < r_cmp_row)))
                r_keep <= 1'b0;
        end
    end

    assign o_stat.col_hit   = r_col_mask[i_cmd.idx];
    assign o_stat.blk_hit   = r_blk_mask[i_cmd.idx];
    assign o_stat.blk_more  = |(r_blk_mask & above);
    assign o_stat.cons_code = r_cons;
    assign o_stat.cur_score = r_cmp_score;
    assign o_stat.keep      = r_keep;

endmodule

// ===== sv/csdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// csdp_ctrl
// Sequencer: load, consensus, score walk, verdict walk, output hold.
// ----------------------------------------------------------------------------
module csdp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  csdp_pkg::t_in   i_item,
    input  csdp_pkg::t_stat i_stat,
    output csdp_pkg::t_cmd  o_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output csdp_pkg::t_out  o_item
);
    import csdp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CONS, S_EMIT_C, S_SCORE, S_VLOAD, S_VCMP, S_EMIT_V
    } t_state;

    t_state           r_state;
    logic             r_in_block, r_blk_end, r_valid;
    logic [ROW_W-1:0] r_r, r_q;
    t_out             r_out;
    logic             accept;
    logic             last_slot;

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_out;
    assign last_slot = (r_r == ROW_W'(MAX_ROWS - 1));

    always_comb begin
        o_cmd = '0;
        o_cmd.load      = accept;
        o_cmd.clr_block = accept && !r_in_block;
        case (r_state)
            S_CONS:  o_cmd.cons = 1'b1;
            S_SCORE: begin
                o_cmd.idx   = r_r;
                o_cmd.score = 1'b1;
                o_cmd.clr_col = last_slot;
            end
            S_VLOAD: begin
                o_cmd.idx      = r_r;
                o_cmd.cmp_load = 1'b1;
            end
            S_VCMP: begin
                o_cmd.idx      = r_q;
                o_cmd.cmp_step = 1'b1;
            end
            default: o_cmd.idx = r_r;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_block <= 1'b0;
            r_blk_end  <= 1'b0;
            r_valid    <= 1'b0;
            r_r        <= '0;
            r_q        <= '0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) begin
                    r_in_block <= 1'b1;
                    if (i_item.last_in_column) begin
                        r_blk_end <= i_item.last_column;
                        r_state   <= S_CONS;
                    end
                end
                S_CONS: r_state <= S_EMIT_C;
                S_EMIT_C: if (!r_valid) begin
                    r_out   <= '{kind: 1'b0, consensus_code: i_stat.cons_code, row_out: '0,
                                 row_score: '0, keep: 1'b0, last: !r_blk_end};
                    r_valid <= 1'b1;
                    r_r     <= '0;
                    r_state <= S_SCORE;
                end
                S_SCORE: begin
                    if (last_slot) begin
                        r_r <= '0;
                        if (r_blk_end) begin
                            r_in_block <= 1'b0;
                            r_state    <= S_VLOAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_r <= r_r + ROW_W'(1);
                    end
                end
                S_VLOAD: begin
                    // skip rows not seen in this block
                    if (i_stat.blk_hit) begin
                        r_q     <= '0;
                        r_state <= S_VCMP;
                    end else if (!last_slot) begin
                        r_r <= r_r + ROW_W'(1);
                    end else begin
                        r_r     <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_VCMP: begin
                    if (r_q == ROW_W'(MAX_ROWS - 1))
                        r_state <= S_EMIT_V;
                    else
                        r_q <= r_q + ROW_W'(1);
                end
                S_EMIT_V: if (!r_valid) begin
                    // the verdict is final when no later row is in the block
                    r_out   <= '{kind: 1'b1, consensus_code: '0, row_out: r_r,
                                 row_score: i_stat.cur_score, keep: i_stat.keep,
                                 last: !i_stat.blk_more};
                    r_valid <= 1'b1;
                    if (i_stat.blk_more) begin
                        r_r     <= r_r + ROW_W'(1);
                        r_state <= S_VLOAD;
                    end else begin
                        r_r     <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/csdp_last.sv =====
// ----------------------------------------------------------------------------
// csdp_last
// Output stage: one result register between the sequencer and the port.
// ----------------------------------------------------------------------------
module csdp_last (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  csdp_pkg::t_out i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output csdp_pkg::t_out o_item
);
    import csdp_pkg::*;

    t_out r_out;
    logic r_valid;

    assign o_valid = r_valid;
    assign o_item  = r_out;
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) r_out <= i_item;
        end
    end

endmodule
